// ===== src/tcce_pkg.sv =====
`default_nettype none

package tcce_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OUT_W  = 11;

    localparam logic [BYTE_W-1:0] TEXT_ATTR  = 8'h0F;
    localparam logic [BYTE_W-1:0] BODY_ATTR  = 8'h1F;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;

    typedef enum logic [2:0] {
        CH_NUL,
        CH_NL,
        CH_TAB,
        CH_BS,
        CH_PRINT
    } t_ch_class;

    // which result word the datapath builds
    typedef enum logic [2:0] {
        RES_PRINT,
        RES_CLEAR,
        RES_CTRL,
        RES_TSPACE,
        RES_PAD,
        RES_BS_RUN,
        RES_BS_CELL
    } t_res_sel;

    typedef enum logic [1:0] {
        FLAG_ZERO,
        FLAG_ONE,
        FLAG_TXT
    } t_flag_val;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CUR_KEEP,
        CUR_PTR,
        CUR_ZERO
    } t_cur_op;

    typedef struct packed {
        logic      capture;
        logic      emit;
        t_res_sel  res_sel;
        logic      last;
        logic      mem_we;
        logic      addr_from_ptr;
        t_flag_val wdata;
        logic      mem_rd;
        t_ptr_op   ptr_op;
        t_cur_op   cur_op;
    } t_dp_cmd;

    typedef struct packed {
        logic      kind;
        t_ch_class ch_class;
        logic      out_free;
        logic      pad_empty;
        logic      walk_stop;
        logic      cur_zero;
        logic      ptr_zero;
        logic      ptr_last;
        logic      rd_flag;
        logic      run_nonempty;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/tcce_ctrl.sv =====
`default_nettype none

module tcce_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tcce_pkg::t_dp_status i_status,
    output tcce_pkg::t_dp_cmd    o_cmd
);

    import tcce_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_PRINT,
        S_CLR_EMIT,
        S_PAD_CTRL,
        S_PAD_SPACE,
        S_PAD_WALK,
        S_PAD_EMIT,
        S_BS_CTRL,
        S_BS_RD,
        S_BS_CHK,
        S_BS_RUN,
        S_BS_CELL,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture       = 1'b0;
        o_cmd.emit          = 1'b0;
        o_cmd.res_sel       = RES_CTRL;
        o_cmd.last          = 1'b0;
        o_cmd.mem_we        = 1'b0;
        o_cmd.addr_from_ptr = 1'b0;
        o_cmd.wdata         = FLAG_ZERO;
        o_cmd.mem_rd        = 1'b0;
        o_cmd.ptr_op        = PTR_HOLD;
        o_cmd.cur_op        = CUR_KEEP;

        case (r_state)
            S_SWEEP: begin
                o_cmd.mem_we        = 1'b1;
                o_cmd.addr_from_ptr = 1'b1;
                o_cmd.wdata         = FLAG_ZERO;
                if (i_status.ptr_last) begin
                    o_cmd.cur_op = CUR_ZERO;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.ptr_op  = PTR_LOAD;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.kind) begin
                    n_state = S_CLR_EMIT;
                end else begin
                    case (i_status.ch_class)
                        CH_NUL:   n_state = S_IDLE;
                        CH_NL:    n_state = S_PAD_CTRL;
                        CH_TAB:   n_state = S_PAD_CTRL;
                        CH_BS:    n_state = S_BS_CTRL;
                        default:  n_state = S_PRINT;
                    endcase
                end
            end
            S_PRINT: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_PRINT;
                    o_cmd.last    = 1'b1;
                    o_cmd.mem_we  = 1'b1;
                    o_cmd.wdata   = FLAG_TXT;
                    o_cmd.ptr_op  = PTR_INC;
                    n_state       = S_COMMIT;
                end
            end
            S_CLR_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_CLEAR;
                    o_cmd.last    = 1'b1;
                    o_cmd.ptr_op  = PTR_ZERO;
                    n_state       = S_SWEEP;
                end
            end
            S_PAD_CTRL: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_CTRL;
                    n_state       = S_PAD_SPACE;
                end
            end
            S_PAD_SPACE: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_TSPACE;
                    o_cmd.last    = i_status.pad_empty;
                    o_cmd.mem_we  = 1'b1;
                    o_cmd.wdata   = FLAG_ONE;
                    o_cmd.ptr_op  = PTR_INC;
                    n_state       = i_status.pad_empty ? S_COMMIT : S_PAD_WALK;
                end
            end
            S_PAD_WALK: begin
                // one filler cell per cycle until the next stop or screen end
                if (i_status.walk_stop) begin
                    n_state = S_PAD_EMIT;
                end else begin
                    o_cmd.mem_we        = 1'b1;
                    o_cmd.addr_from_ptr = 1'b1;
                    o_cmd.wdata         = FLAG_ZERO;
                    o_cmd.ptr_op        = PTR_INC;
                end
            end
            S_PAD_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_PAD;
                    o_cmd.last    = 1'b1;
                    n_state       = S_COMMIT;
                end
            end
            S_BS_CTRL: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_CTRL;
                    if (i_status.cur_zero) begin
                        n_state = S_BS_CELL;
                    end else begin
                        o_cmd.ptr_op = PTR_DEC;
                        n_state      = S_BS_RD;
                    end
                end
            end
            S_BS_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_BS_CHK;
            end
            S_BS_CHK: begin
                if (i_status.ptr_zero || i_status.rd_flag) begin
                    n_state = i_status.run_nonempty ? S_BS_RUN : S_BS_CELL;
                end else begin
                    o_cmd.ptr_op = PTR_DEC;
                    n_state      = S_BS_RD;
                end
            end
            S_BS_RUN: begin
                // skipped cells were all read as clear, so no flag writes here
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_BS_RUN;
                    n_state       = S_BS_CELL;
                end
            end
            S_BS_CELL: begin
                if (i_status.out_free) begin
                    o_cmd.emit          = 1'b1;
                    o_cmd.res_sel       = RES_BS_CELL;
                    o_cmd.last          = 1'b1;
                    o_cmd.mem_we        = 1'b1;
                    o_cmd.addr_from_ptr = 1'b1;
                    o_cmd.wdata         = FLAG_ZERO;
                    n_state             = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.cur_op = CUR_PTR;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/tcce_dpath.sv =====
`default_nettype none

module tcce_dpath #(
    parameter int unsigned COLUMNS  = 80,
    parameter int unsigned ROWS     = 24,
    parameter int unsigned TAB_STOP = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_kind,
    input  wire  [tcce_pkg::BYTE_W-1:0]           i_char_code,
    input  wire  [tcce_pkg::BYTE_W-1:0]           i_colour,
    input  tcce_pkg::t_dp_cmd                     i_cmd,
    output tcce_pkg::t_dp_status                  o_status,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_serial_valid,
    output logic [tcce_pkg::BYTE_W-1:0]           o_serial_byte,
    output logic                                  o_write_valid,
    output logic [tcce_pkg::OUT_W-1:0]            o_first_cell,
    output logic [tcce_pkg::OUT_W-1:0]            o_cell_count,
    output logic [tcce_pkg::BYTE_W-1:0]           o_glyph,
    output logic [tcce_pkg::BYTE_W-1:0]           o_attribute,
    output logic                                  o_attr_only,
    output logic                                  o_last
);

    import tcce_pkg::*;

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned PW    = $clog2(CELLS + 1);
    localparam int unsigned CLW   = $clog2(COLUMNS);
    localparam int unsigned TBW   = $clog2(TAB_STOP);

    // captured word
    logic              r_kind;
    logic [BYTE_W-1:0] r_char;
    logic [BYTE_W-1:0] r_colour;

    // cursor and walking pointer, each with its column and tab phase
    logic [AW-1:0]  r_cursor,  n_cursor;
    logic [CLW-1:0] r_cur_col, n_cur_col;
    logic [TBW-1:0] r_cur_tab, n_cur_tab;
    logic [PW-1:0]  r_ptr,     n_ptr;
    logic [CLW-1:0] r_ptr_col, n_ptr_col;
    logic [TBW-1:0] r_ptr_tab, n_ptr_tab;

    logic           r_flags [CELLS];
    logic           r_rd_flag;
    logic [AW-1:0]  mem_addr;
    logic           mem_wbit;

    logic           r_out_valid;
    logic           r_serial_valid;
    logic [BYTE_W-1:0] r_serial_byte;
    logic           r_write_valid;
    logic [OUT_W-1:0] r_first_cell;
    logic [OUT_W-1:0] r_cell_count;
    logic [BYTE_W-1:0] r_glyph;
    logic [BYTE_W-1:0] r_attribute;
    logic           r_attr_only;
    logic           r_last;

    logic           n_serial_valid;
    logic [BYTE_W-1:0] n_serial_byte;
    logic           n_write_valid;
    logic [PW-1:0]  n_first_p;
    logic [PW-1:0]  n_count_p;
    logic [BYTE_W-1:0] n_glyph;
    logic [BYTE_W-1:0] n_attribute;
    logic           n_attr_only;
    logic [PW+OUT_W-1:0] first_ext;
    logic [PW+OUT_W-1:0] count_ext;

    logic [PW-1:0]  cur_ext;
    logic           is_nl;
    logic           is_text;
    logic           out_free;
    t_ch_class      ch_class;

    assign cur_ext  = PW'(r_cursor);
    assign is_nl    = (r_char == CHAR_NL);
    assign is_text  = (r_colour == TEXT_ATTR);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_char)
            CHAR_NUL: ch_class = CH_NUL;
            CHAR_NL:  ch_class = CH_NL;
            CHAR_TAB: ch_class = CH_TAB;
            CHAR_BS:  ch_class = CH_BS;
            default:  ch_class = CH_PRINT;
        endcase
    end

    always_comb begin
        o_status.kind      = r_kind;
        o_status.ch_class  = ch_class;
        o_status.out_free  = out_free;
        o_status.pad_empty = (r_cursor == AW'(CELLS - 1)) ||
                             (is_nl ? (r_cur_col == CLW'(COLUMNS - 1))
                                    : (r_cur_tab == TBW'(TAB_STOP - 1)));
        o_status.walk_stop = (r_ptr == PW'(CELLS)) ||
                             (is_nl ? (r_ptr_col == '0) : (r_ptr_tab == '0));
        o_status.cur_zero     = (r_cursor == '0);
        o_status.ptr_zero     = (r_ptr == '0);
        o_status.ptr_last     = (r_ptr == PW'(CELLS - 1));
        o_status.rd_flag      = r_rd_flag;
        o_status.run_nonempty = (cur_ext > (r_ptr + PW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_char   <= i_char_code;
            r_colour <= i_colour;
        end
    end

    always_comb begin
        n_ptr     = r_ptr;
        n_ptr_col = r_ptr_col;
        n_ptr_tab = r_ptr_tab;
        case (i_cmd.ptr_op)
            PTR_LOAD: begin
                n_ptr     = cur_ext;
                n_ptr_col = r_cur_col;
                n_ptr_tab = r_cur_tab;
            end
            PTR_ZERO: begin
                n_ptr     = '0;
                n_ptr_col = '0;
                n_ptr_tab = '0;
            end
            PTR_INC: begin
                n_ptr     = r_ptr + PW'(1);
                n_ptr_col = (r_ptr_col == CLW'(COLUMNS - 1)) ? '0 : r_ptr_col + CLW'(1);
                n_ptr_tab = (r_ptr_tab == TBW'(TAB_STOP - 1)) ? '0 : r_ptr_tab + TBW'(1);
            end
            PTR_DEC: begin
                n_ptr     = r_ptr - PW'(1);
                n_ptr_col = (r_ptr_col == '0) ? CLW'(COLUMNS - 1) : r_ptr_col - CLW'(1);
                n_ptr_tab = (r_ptr_tab == '0) ? TBW'(TAB_STOP - 1) : r_ptr_tab - TBW'(1);
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_comb begin
        n_cursor  = r_cursor;
        n_cur_col = r_cur_col;
        n_cur_tab = r_cur_tab;
        case (i_cmd.cur_op)
            CUR_PTR: begin
                // stepping past the last cell wraps to cell 0
                if (r_ptr == PW'(CELLS)) begin
                    n_cursor  = '0;
                    n_cur_col = '0;
                    n_cur_tab = '0;
                end else begin
                    n_cursor  = r_ptr[AW-1:0];
                    n_cur_col = r_ptr_col;
                    n_cur_tab = r_ptr_tab;
                end
            end
            CUR_ZERO: begin
                n_cursor  = '0;
                n_cur_col = '0;
                n_cur_tab = '0;
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_cur_col <= '0;
            r_cur_tab <= '0;
            r_ptr     <= '0;
            r_ptr_col <= '0;
            r_ptr_tab <= '0;
        end else begin
            r_cursor  <= n_cursor;
            r_cur_col <= n_cur_col;
            r_cur_tab <= n_cur_tab;
            r_ptr     <= n_ptr;
            r_ptr_col <= n_ptr_col;
            r_ptr_tab <= n_ptr_tab;
        end
    end

    // text flag store
    assign mem_addr = i_cmd.addr_from_ptr ? r_ptr[AW-1:0] : r_cursor;

    always_comb begin
        case (i_cmd.wdata)
            FLAG_ONE: mem_wbit = 1'b1;
            FLAG_TXT: mem_wbit = is_text;
            default:  mem_wbit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_flags[mem_addr] <= mem_wbit;
        end
        if (i_cmd.mem_rd) begin
            r_rd_flag <= r_flags[r_ptr[AW-1:0]];
        end
    end

    // result word
    always_comb begin
        n_serial_valid = 1'b0;
        n_serial_byte  = '0;
        n_write_valid  = 1'b1;
        n_first_p      = '0;
        n_count_p      = PW'(1);
        n_glyph        = SPACE_CHAR;
        n_attribute    = BODY_ATTR;
        n_attr_only    = 1'b0;
        case (i_cmd.res_sel)
            RES_PRINT: begin
                n_serial_valid = is_text;
                n_serial_byte  = is_text ? r_char : '0;
                n_first_p      = cur_ext;
                n_glyph        = r_char;
                n_attribute    = r_colour;
            end
            RES_CLEAR: begin
                n_count_p = PW'(CELLS);
            end
            RES_CTRL: begin
                n_serial_valid = 1'b1;
                n_serial_byte  = r_char;
                n_write_valid  = 1'b0;
                n_count_p      = '0;
                n_glyph        = '0;
                n_attribute    = '0;
            end
            RES_TSPACE: begin
                n_serial_valid = 1'b1;
                n_serial_byte  = SPACE_CHAR;
                n_first_p      = cur_ext;
                n_attribute    = TEXT_ATTR;
            end
            RES_PAD: begin
                n_first_p = cur_ext + PW'(1);
                n_count_p = r_ptr - cur_ext - PW'(1);
            end
            RES_BS_RUN: begin
                n_first_p   = r_ptr + PW'(1);
                n_count_p   = cur_ext - r_ptr - PW'(1);
                n_glyph     = '0;
                n_attr_only = 1'b1;
            end
            RES_BS_CELL: begin
                n_first_p = r_ptr;
            end
            default: begin
                n_write_valid = 1'b0;
            end
        endcase
    end

    assign first_ext = {{OUT_W{1'b0}}, n_first_p};
    assign count_ext = {{OUT_W{1'b0}}, n_count_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_serial_valid <= n_serial_valid;
            r_serial_byte  <= n_serial_byte;
            r_write_valid  <= n_write_valid;
            r_first_cell   <= first_ext[OUT_W-1:0];
            r_cell_count   <= count_ext[OUT_W-1:0];
            r_glyph        <= n_glyph;
            r_attribute    <= n_attribute;
            r_attr_only    <= n_attr_only;
            r_last         <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_serial_valid = r_serial_valid;
    assign o_serial_byte  = r_serial_byte;
    assign o_write_valid  = r_write_valid;
    assign o_first_cell   = r_first_cell;
    assign o_cell_count   = r_cell_count;
    assign o_glyph        = r_glyph;
    assign o_attribute    = r_attribute;
    assign o_attr_only    = r_attr_only;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== src/text_console_cursor_engine_unit.sv =====
`default_nettype none

// Text console cursor engine: takes one word at a time (a character with its
// attribute, or a clear-screen command) and returns up to three result words
// (none for NUL) describing serial echo and screen cell runs, the final one
// marked by o_last. No new word is accepted until the previous one is processed.
// Newline and tab write the flag store one filler cell per cycle (up to
// COLUMNS-1 or TAB_STOP-1 filler cells). Backspace walks back to the nearest
// text cell or cell 0 with one registered flag-store read per step, and
// recolors the filler cells it passes. Clear, and the clearing pass after
// reset, sweep the whole flag store (ROWS*COLUMNS cells) one cell per cycle,
// during which no word is accepted. Stalls on the result side hold the engine
// in its emit states.
module text_console_cursor_engine_unit #(
    parameter int unsigned COLUMNS  = 80,
    parameter int unsigned ROWS     = 24,
    parameter int unsigned TAB_STOP = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_kind,
    input  wire  [tcce_pkg::BYTE_W-1:0]      i_char_code,
    input  wire  [tcce_pkg::BYTE_W-1:0]      i_colour,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_serial_valid,
    output logic [tcce_pkg::BYTE_W-1:0]      o_serial_byte,
    output logic                             o_write_valid,
    output logic [tcce_pkg::OUT_W-1:0]       o_first_cell,
    output logic [tcce_pkg::OUT_W-1:0]       o_cell_count,
    output logic [tcce_pkg::BYTE_W-1:0]      o_glyph,
    output logic [tcce_pkg::BYTE_W-1:0]      o_attribute,
    output logic                             o_attr_only,
    output logic                             o_last
);

    import tcce_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tcce_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_colour       (i_colour),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_serial_valid (o_serial_valid),
        .o_serial_byte  (o_serial_byte),
        .o_write_valid  (o_write_valid),
        .o_first_cell   (o_first_cell),
        .o_cell_count   (o_cell_count),
        .o_glyph        (o_glyph),
        .o_attribute    (o_attribute),
        .o_attr_only    (o_attr_only),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== bench/screen_word_checker.sv =====
`default_nettype none

module screen_word_checker #(
    parameter int unsigned COLUMNS  = 80,
    parameter int unsigned ROWS     = 24,
    parameter int unsigned TAB_STOP = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire                          i_kind,
    input  wire  [tcce_pkg::BYTE_W-1:0]  i_char_code,
    input  wire  [tcce_pkg::BYTE_W-1:0]  i_colour,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire                          i_serial_valid,
    input  wire  [tcce_pkg::BYTE_W-1:0]  i_serial_byte,
    input  wire                          i_write_valid,
    input  wire  [tcce_pkg::OUT_W-1:0]   i_first_cell,
    input  wire  [tcce_pkg::OUT_W-1:0]   i_cell_count,
    input  wire  [tcce_pkg::BYTE_W-1:0]  i_glyph,
    input  wire  [tcce_pkg::BYTE_W-1:0]  i_attribute,
    input  wire                          i_attr_only,
    input  wire                          i_last,
    output int                           o_fail_count,
    output int                           o_words_due
);

    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic               serial_valid;
        logic [BYTE_W-1:0]  serial_byte;
        logic               write_valid;
        logic [OUT_W-1:0]   first_cell;
        logic [OUT_W-1:0]   cell_count;
        logic [BYTE_W-1:0]  glyph;
        logic [BYTE_W-1:0]  attribute;
        logic               attr_only;
        logic               last;
    } t_screen_word;

    t_screen_word words_due[$];
    t_screen_word held_word;
    t_screen_word due_word;
    bit           word_held;
    bit           cell_is_text [CELLS];
    int           cursor_cell;
    int           fail_count = 0;
    int           due_count  = 0;

    assign o_fail_count = fail_count;
    assign o_words_due  = due_count;

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("%s is 0x%0h, expected 0x%0h (word for cell %0d)",
                             name, got, want, due_word.first_cell));
        end
    endtask

    // the last word of an item is only known once the item is done, so one is held back
    task automatic queue_word(input logic sv, input logic [BYTE_W-1:0] sb, input logic wv,
                              input int first, input int count,
                              input logic [BYTE_W-1:0] glyph,
                              input logic [BYTE_W-1:0] attr, input logic ao);
        if (word_held) begin
            words_due.push_back(held_word);
        end
        held_word = '{sv, sb, wv, OUT_W'(first), OUT_W'(count), glyph, attr, ao, 1'b0};
        word_held = 1'b1;
    endtask

    task automatic close_item();
        if (word_held) begin
            held_word.last = 1'b1;
            words_due.push_back(held_word);
            word_held = 1'b0;
        end
    endtask

    task automatic move_cursor(input int c);
        cursor_cell = (c >= CELLS) ? 0 : c;
    endtask

    task automatic blank_flags(input int first, input int count);
        for (int i = first; i < first + count && i < CELLS; i++) begin
            cell_is_text[i] = 1'b0;
        end
    endtask

    // newline or tab: control byte, a text space, then body filler up to the stop
    task automatic pad_run(input logic [BYTE_W-1:0] ctrl, input int modulus);
        int c;
        int n;
        int pad;
        c = cursor_cell;
        queue_word(1'b1, ctrl, 1'b0, 0, 0, 8'h00, 8'h00, 1'b0);
        queue_word(1'b1, SPACE_CHAR, 1'b1, c, 1, SPACE_CHAR, TEXT_ATTR, 1'b0);
        cell_is_text[c] = 1'b1;
        n = c + 1;
        if (n >= CELLS) begin
            move_cursor(0);
        end else begin
            pad = (modulus - n % modulus) % modulus;
            if (pad > CELLS - n) begin
                pad = CELLS - n;
            end
            if (pad > 0) begin
                queue_word(1'b0, 8'h00, 1'b1, n, pad, SPACE_CHAR, BODY_ATTR, 1'b0);
                blank_flags(n, pad);
            end
            move_cursor(n + pad);
        end
    endtask

    // backspace: walk down to the nearest text cell (or cell 0), recolor the filler
    task automatic rub_out();
        int c;
        int p;
        c = cursor_cell;
        queue_word(1'b1, CHAR_BS, 1'b0, 0, 0, 8'h00, 8'h00, 1'b0);
        if (c == 0) begin
            queue_word(1'b0, 8'h00, 1'b1, 0, 1, SPACE_CHAR, BODY_ATTR, 1'b0);
            cell_is_text[0] = 1'b0;
        end else begin
            p = c - 1;
            while (p > 0 && !cell_is_text[p]) begin
                p--;
            end
            if (c - 1 > p) begin
                queue_word(1'b0, 8'h00, 1'b1, p + 1, c - 1 - p, 8'h00, BODY_ATTR, 1'b1);
                blank_flags(p + 1, c - 1 - p);
            end
            queue_word(1'b0, 8'h00, 1'b1, p, 1, SPACE_CHAR, BODY_ATTR, 1'b0);
            cell_is_text[p] = 1'b0;
            move_cursor(p);
        end
    endtask

    task automatic advance_console(input logic kind, input logic [BYTE_W-1:0] ch,
                                   input logic [BYTE_W-1:0] col);
        logic txt;
        if (cursor_cell >= CELLS) begin
            move_cursor(0);
        end
        if (kind) begin
            queue_word(1'b0, 8'h00, 1'b1, 0, CELLS, SPACE_CHAR, BODY_ATTR, 1'b0);
            blank_flags(0, CELLS);
            move_cursor(0);
        end else if (ch == CHAR_NL) begin
            pad_run(ch, COLUMNS);
        end else if (ch == CHAR_TAB) begin
            pad_run(ch, TAB_STOP);
        end else if (ch == CHAR_BS) begin
            rub_out();
        end else if (ch != CHAR_NUL) begin
            txt = (col == TEXT_ATTR);
            queue_word(txt, txt ? ch : 8'h00, 1'b1, cursor_cell, 1, ch, col, 1'b0);
            cell_is_text[cursor_cell] = txt;
            move_cursor(cursor_cell + 1);
        end
        close_item();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_due.delete();
            word_held = 1'b0;
            blank_flags(0, CELLS);
            cursor_cell = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                advance_console(i_kind, i_char_code, i_colour);
            end
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    report($sformatf("result word for cell %0d with nothing pending",
                                     i_first_cell));
                end else begin
                    due_word = words_due.pop_front();
                    check_field("serial_valid", i_serial_valid, due_word.serial_valid);
                    check_field("serial_byte", i_serial_byte, due_word.serial_byte);
                    check_field("write_valid", i_write_valid, due_word.write_valid);
                    check_field("first_cell", i_first_cell, due_word.first_cell);
                    check_field("cell_count", i_cell_count, due_word.cell_count);
                    check_field("glyph", i_glyph, due_word.glyph);
                    check_field("attribute", i_attribute, due_word.attribute);
                    check_field("attr_only", i_attr_only, due_word.attr_only);
                    check_field("last", i_last, due_word.last);
                end
            end
        end
        due_count = words_due.size();
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

    import tcce_pkg::*;

    localparam int unsigned COLUMNS  = 80;
    localparam int unsigned ROWS     = 24;
    localparam int unsigned TAB_STOP = 4;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // a clear sweeps every cell once, so let that much time pass after the last word
    localparam int DRAIN_CYCLES   = COLUMNS * ROWS + 100;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [BYTE_W-1:0]  char_code;
    logic [BYTE_W-1:0]  colour;
    logic               out_valid;
    logic               out_ready;
    logic               serial_valid;
    logic [BYTE_W-1:0]  serial_byte;
    logic               write_valid;
    logic [OUT_W-1:0]   first_cell;
    logic [OUT_W-1:0]   cell_count;
    logic [BYTE_W-1:0]  glyph;
    logic [BYTE_W-1:0]  attribute;
    logic               attr_only;
    logic               last;

    int fail_count;
    int words_due;
    int cycle_count = 0;
    bit no_idle     = 1'b0;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    text_console_cursor_engine_unit #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_char_code    (char_code),
        .i_colour       (colour),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_serial_valid (serial_valid),
        .o_serial_byte  (serial_byte),
        .o_write_valid  (write_valid),
        .o_first_cell   (first_cell),
        .o_cell_count   (cell_count),
        .o_glyph        (glyph),
        .o_attribute    (attribute),
        .o_attr_only    (attr_only),
        .o_last         (last)
    );

    screen_word_checker #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (kind),
        .i_char_code    (char_code),
        .i_colour       (colour),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_serial_valid (serial_valid),
        .i_serial_byte  (serial_byte),
        .i_write_valid  (write_valid),
        .i_first_cell   (first_cell),
        .i_cell_count   (cell_count),
        .i_glyph        (glyph),
        .i_attribute    (attribute),
        .i_attr_only    (attr_only),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_words_due    (words_due)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic k, input logic [BYTE_W-1:0] ch,
                             input logic [BYTE_W-1:0] col);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind      = k;
        char_code = ch;
        colour    = col;
        in_valid  = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] col);
        send_word(KIND_CHAR, ch, col);
    endtask

    task automatic send_random_word();
        int pick;
        logic [BYTE_W-1:0] col;
        pick = $urandom_range(0, 99);
        col  = ($urandom_range(0, 1) == 0) ? TEXT_ATTR : BYTE_W'($urandom_range(0, 255));
        if (pick < 3) begin
            send_word(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)), col);
        end else if (pick < 8) begin
            send_char(CHAR_NUL, col);
        end else if (pick < 20) begin
            send_char(CHAR_NL, col);
        end else if (pick < 35) begin
            send_char(CHAR_TAB, col);
        end else if (pick < 52) begin
            send_char(CHAR_BS, col);
        end else begin
            send_char(BYTE_W'($urandom_range(0, 255)), col);
        end
    endtask

    // walk the cursor to the very last cell, then cross the end of the screen
    task automatic run_to_screen_end();
        send_word(KIND_CLEAR, 8'h00, 8'h00);
        repeat (ROWS - 1) send_char(CHAR_NL, BYTE_W'($urandom_range(0, 255)));
        repeat ((COLUMNS - TAB_STOP) / TAB_STOP) send_char(CHAR_TAB, 8'h00);
        repeat (TAB_STOP - 1) begin
            send_char(BYTE_W'($urandom_range(32, 255)),
                      ($urandom_range(0, 1) == 0) ? TEXT_ATTR : BODY_ATTR);
        end
        case ($urandom_range(0, 2))
            0: send_char(CHAR_NL, 8'h00);
            1: send_char(CHAR_TAB, 8'h00);
            default: send_char(BYTE_W'($urandom_range(32, 255)), TEXT_ATTR);
        endcase
        send_char(CHAR_BS, 8'h00);
    endtask

    // result side: random stall before each word, none while no_idle is set
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_CHAR;
        char_code = 8'h00;
        colour    = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(KIND_CLEAR, 8'h00, 8'h00);
        send_char(8'h41, TEXT_ATTR);
        send_char(8'hFF, 8'hFF);
        send_char(8'h01, 8'h00);
        send_char(CHAR_NUL, 8'hAA);
        send_char(CHAR_TAB, 8'h55);       // lands on a stop: empty pad
        send_char(CHAR_TAB, TEXT_ATTR);   // full pad
        send_char(CHAR_BS, 8'h00);        // recolors the pad back to the text space
        send_char(CHAR_BS, 8'h00);
        send_char(CHAR_BS, 8'h00);        // walks past body cells down to cell 0
        send_char(CHAR_BS, 8'h00);        // at cell 0
        send_char(CHAR_NL, 8'hFF);
        send_word(KIND_CLEAR, 8'hFF, 8'hFF);
        send_char(8'h78, BODY_ATTR);
        send_char(8'h79, BODY_ATTR);
        send_char(CHAR_BS, 8'h00);
        send_char(8'h7F, TEXT_ATTR);
        send_char(8'h80, 8'hF0);
        send_char(CHAR_NL, 8'h00);
        send_char(CHAR_TAB, 8'h00);
        send_char(CHAR_BS, 8'h00);
        send_char(8'h20, TEXT_ATTR);

        repeat (4) begin
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (8) send_random_word();
        end
        no_idle = ($urandom_range(0, 1) == 0);
        run_to_screen_end();
        no_idle = 1'b0;
        repeat (10) send_random_word();

        in_valid = 1'b0;
        while (words_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && words_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
